### src/affine_point_transform_assert.svh
`ifndef AFFINE_POINT_TRANSFORM_ASSERT_SVH
`define AFFINE_POINT_TRANSFORM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define APT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define APT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/apt_pkg.sv
package apt_pkg;

	// transform selection codes
	localparam logic [2:0] KIND_AFFINE    = 3'd0;
	localparam logic [2:0] KIND_ROT       = 3'd1;
	localparam logic [2:0] KIND_ROT_T     = 3'd2;
	localparam logic [2:0] KIND_INV_RIGID = 3'd3;
	localparam logic [2:0] KIND_PROJ      = 3'd4;

	// register file
	localparam int unsigned NUM_REGS  = 8;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned REG_W     = 64;
	localparam int unsigned ELEM_W    = 32;
	localparam int unsigned OUT_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

	typedef logic [REG_W-1:0] cfg_word_t;

endpackage

### src/affine_point_transform.sv
// affine point transform: one 3d point times a 4x4 fixed-point matrix
//
// input channel: in_valid / in_stall with kind, px, py, pz; an item is taken
//   on a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with qx, qy, qz, saturated, zero_w;
//   the receiver holds out_stall high to keep the current item in place
// config channel: cfg_valid / cfg_ready, cfg_index picks one of the eight
//   packed matrix registers, cfg_data is the 64-bit word; cfg_ready is
//   always high and indexes past the last register are dropped
// depth: set by the quotient pipeline of the projective divide, one
//   quotient bit per stage
// throughput: one item per cycle while the output is not stalled; every
//   stage, including the divider, is a plain register stage shared by all kinds
// stall: a stalled output freezes the whole pipe; in_stall follows that
//   freeze, so no item is dropped or repeated
// reset: valid bits clear and the matrix returns to identity
`include "affine_point_transform_assert.svh"

module affine_point_transform #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input items
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     kind,
	input  logic signed [31:0]             px,
	input  logic signed [31:0]             py,
	input  logic signed [31:0]             pz,
	// result items
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [31:0]             qx,
	output logic signed [31:0]             qy,
	output logic signed [31:0]             qz,
	output logic                           saturated,
	output logic                           zero_w,
	// register writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [apt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [apt_pkg::REG_W-1:0]      cfg_data
);

	// 32-bit element times 33-bit operand
	localparam int PROD_W = apt_pkg::ELEM_W + 33;
	localparam int SH_W   = PROD_W - FRAC_BITS;
	// three products plus a translation
	localparam int ACC_W  = SH_W + 2;
	localparam int CMP_W  = ACC_W + FRAC_BITS + COORD_WIDTH;
	localparam int CW     = COORD_WIDTH;

	localparam logic [63:0] ONE_LO = 64'd1 << FRAC_BITS;
	localparam logic [63:0] ONE_HI = 64'd1 << (FRAC_BITS + 32);

	// identity matrix, register 0 in the low word
	localparam logic [apt_pkg::NUM_REGS-1:0][apt_pkg::REG_W-1:0] RST_VAL =
		{ONE_HI, 64'd0, ONE_LO, 64'd0, 64'd0, ONE_HI, 64'd0, ONE_LO};

	localparam logic signed [ACC_W-1:0] CLAMP_HI =
		signed'({{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] CLAMP_LO =
		signed'({{(ACC_W-CW+1){1'b1}}, {(CW-1){1'b0}}});
	localparam logic [CW-1:0] Q_HI = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] Q_LO = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic                   proj;
		logic                   zw;
		logic                   sat;
		logic [2:0]             neg;
		logic [2:0]             ovf;
		logic [2:0][CW-1:0]     clamped;
		logic [ACC_W-1:0]       den;
	} side_t;

	// floor shift of a product, narrowed to the accumulator
	function automatic logic signed [ACC_W-1:0] trunc_prod(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] sh;
		sh = p >>> FRAC_BITS;
		return ACC_W'(signed'(sh[SH_W-1:0]));
	endfunction

	function automatic logic signed [31:0] OUT_SEXT(input logic [CW-1:0] v);
		return 32'(signed'(v));
	endfunction

	// ------------------------------------------------------------------
	// matrix registers
	// ------------------------------------------------------------------
	apt_pkg::cfg_word_t cfg_q [apt_pkg::NUM_REGS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < apt_pkg::NUM_REGS; r++) begin
				cfg_q[r] <= RST_VAL[r];
			end
		end else if (cfg_valid && cfg_ready && (cfg_index < apt_pkg::NUM_REGS)) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// unpack into a 4x4 element grid
	logic signed [31:0] mat [4][4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mat[r][c] = signed'(cfg_q[r*2 + (c >> 1)][32*(c & 1) +: 32]);
			end
		end
	end

	// the whole pipe moves together; a held result freezes every stage
	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// ------------------------------------------------------------------
	// stage 1: operand selection per kind
	// ------------------------------------------------------------------
	logic signed [32:0] pt [3];
	logic signed [31:0] sel_a [3][3];
	logic signed [32:0] sel_b [3];
	logic signed [31:0] sel_c [3];

	always_comb begin
		pt[0] = 33'(signed'(px[CW-1:0]));
		pt[1] = 33'(signed'(py[CW-1:0]));
		pt[2] = 33'(signed'(pz[CW-1:0]));
		for (int i = 0; i < 3; i++) begin
			sel_b[i] = pt[i];
			sel_c[i] = '0;
			for (int j = 0; j < 3; j++) begin
				sel_a[i][j] = mat[i][j];
			end
		end
		case (kind)
			apt_pkg::KIND_ROT: begin
			end
			apt_pkg::KIND_ROT_T: begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						sel_a[i][j] = mat[j][i];
					end
				end
			end
			apt_pkg::KIND_INV_RIGID: begin
				// p - t stays exact in 33 bits
				for (int i = 0; i < 3; i++) begin
					sel_b[i] = pt[i] - 33'(mat[i][3]);
					for (int j = 0; j < 3; j++) begin
						sel_a[i][j] = mat[j][i];
					end
				end
			end
			default: begin
				// affine, projective and unused codes
				for (int i = 0; i < 3; i++) begin
					sel_c[i] = mat[i][3];
				end
			end
		endcase
	end

	logic               valid_s1;
	logic               proj_s1;
	logic signed [31:0] op_a_s1 [3][3];
	logic signed [32:0] op_b_s1 [3];
	logic signed [31:0] add_s1 [3];
	logic signed [31:0] op_w_s1 [3];
	logic signed [32:0] pt_s1 [3];
	logic signed [31:0] wadd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			proj_s1 <= (kind == apt_pkg::KIND_PROJ);
			op_a_s1 <= sel_a;
			op_b_s1 <= sel_b;
			add_s1  <= sel_c;
			pt_s1   <= pt;
			for (int j = 0; j < 3; j++) begin
				op_w_s1[j] <= mat[3][j];
			end
			wadd_s1 <= mat[3][3];
		end
	end

	// ------------------------------------------------------------------
	// stage 2: twelve products
	// ------------------------------------------------------------------
	logic                     valid_s2;
	logic                     proj_s2;
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic signed [PROD_W-1:0] wprod_s2 [3];
	logic signed [31:0]       add_s2 [3];
	logic signed [31:0]       wadd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			proj_s2 <= proj_s1;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= op_a_s1[i][j] * op_b_s1[j];
				end
				wprod_s2[i] <= op_w_s1[i] * pt_s1[i];
			end
			add_s2  <= add_s1;
			wadd_s2 <= wadd_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: truncate and sum
	// ------------------------------------------------------------------
	logic                    valid_s3;
	logic                    proj_s3;
	logic signed [ACC_W-1:0] acc_s3 [3];
	logic signed [ACC_W-1:0] w_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			proj_s3 <= proj_s2;
			for (int i = 0; i < 3; i++) begin
				acc_s3[i] <= trunc_prod(prod_s2[i][0]) + trunc_prod(prod_s2[i][1])
					+ trunc_prod(prod_s2[i][2]) + ACC_W'(add_s2[i]);
			end
			w_s3 <= trunc_prod(wprod_s2[0]) + trunc_prod(wprod_s2[1])
				+ trunc_prod(wprod_s2[2]) + ACC_W'(wadd_s2);
		end
	end

	// ------------------------------------------------------------------
	// stage 4: clamp for direct kinds, magnitudes for the divide
	// ------------------------------------------------------------------
	logic [CW-1:0] clamp_c [3];
	logic [2:0]    clip_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			clip_c[i]  = 1'b1;
			if (acc_s3[i] > CLAMP_HI) begin
				clamp_c[i] = Q_HI;
			end else if (acc_s3[i] < CLAMP_LO) begin
				clamp_c[i] = Q_LO;
			end else begin
				clamp_c[i] = acc_s3[i][CW-1:0];
				clip_c[i]  = 1'b0;
			end
		end
	end

	logic             valid_s4;
	logic             proj_s4;
	logic             zw_s4;
	logic             sat_s4;
	logic [CW-1:0]    clamp_s4 [3];
	logic [2:0]       neg_s4;
	logic [ACC_W-1:0] mag_s4 [3];
	logic [ACC_W-1:0] den_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			proj_s4  <= proj_s3;
			zw_s4    <= proj_s3 && (w_s3 == '0);
			sat_s4   <= |clip_c;
			clamp_s4 <= clamp_c;
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= acc_s3[i][ACC_W-1] != w_s3[ACC_W-1];
				mag_s4[i] <= acc_s3[i][ACC_W-1] ? unsigned'(-acc_s3[i]) : unsigned'(acc_s3[i]);
			end
			den_s4 <= w_s3[ACC_W-1] ? unsigned'(-w_s3) : unsigned'(w_s3);
		end
	end

	// ------------------------------------------------------------------
	// stage 5 and on: restoring divide, one quotient bit per stage
	// ------------------------------------------------------------------
	logic                   dv_valid_sk [CW+1];
	side_t                  dv_side_sk [CW+1];
	logic [2:0][ACC_W-1:0]  dv_rem_sk [CW+1];
	logic [2:0][CW-1:0]     dv_num_sk [CW+1];
	logic [2:0][CW-1:0]     dv_quo_sk [CW+1];

	// dividend num * 2^FRAC_BITS; a quotient that needs more than CW bits
	// saturates whatever its sign
	logic [ACC_W+FRAC_BITS-1:0] nsh_c [3];
	side_t                      side_c;

	always_comb begin
		side_c.proj = proj_s4;
		side_c.zw   = zw_s4;
		side_c.sat  = sat_s4;
		side_c.neg  = neg_s4;
		side_c.den  = den_s4;
		for (int i = 0; i < 3; i++) begin
			nsh_c[i]          = {mag_s4[i], {FRAC_BITS{1'b0}}};
			side_c.clamped[i] = clamp_s4[i];
			side_c.ovf[i]     = CMP_W'(nsh_c[i]) >= {{FRAC_BITS{1'b0}}, den_s4, {CW{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_sk[0] <= side_c;
			for (int i = 0; i < 3; i++) begin
				dv_rem_sk[0][i] <= ACC_W'(nsh_c[i] >> CW);
				dv_num_sk[0][i] <= nsh_c[i][CW-1:0];
				dv_quo_sk[0][i] <= '0;
			end
		end
	end

	for (genvar k = 0; k < CW; k++) begin : g_div
		logic [ACC_W:0]   trial [3];
		logic [2:0]       fits;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				trial[i] = {dv_rem_sk[k][i], dv_num_sk[k][i][CW-1]};
				fits[i]  = trial[i] >= {1'b0, dv_side_sk[k].den};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_sk[k+1] <= 1'b0;
			end else if (en) begin
				dv_valid_sk[k+1] <= dv_valid_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_sk[k+1] <= dv_side_sk[k];
				for (int i = 0; i < 3; i++) begin
					dv_rem_sk[k+1][i] <= fits[i]
						? ACC_W'(trial[i] - {1'b0, dv_side_sk[k].den})
						: ACC_W'(trial[i]);
					dv_num_sk[k+1][i] <= dv_num_sk[k][i] << 1;
					dv_quo_sk[k+1][i] <= {dv_quo_sk[k][i][CW-2:0], fits[i]};
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// output register: sign, saturation and the zero-w case
	// ------------------------------------------------------------------
	side_t         fin;
	logic [CW-1:0] res_c [3];
	logic [2:0]    rsat_c;
	logic [CW-1:0] quo;

	always_comb begin
		fin = dv_side_sk[CW];
		quo = '0;
		for (int i = 0; i < 3; i++) begin
			quo       = dv_quo_sk[CW][i];
			rsat_c[i] = 1'b0;
			if (!fin.proj) begin
				res_c[i] = fin.clamped[i];
			end else if (fin.zw) begin
				res_c[i] = '0;
			end else if (fin.ovf[i]) begin
				rsat_c[i] = 1'b1;
				res_c[i]  = fin.neg[i] ? Q_LO : Q_HI;
			end else if (fin.neg[i]) begin
				// magnitude up to 2^(CW-1) still fits on the negative side
				if (quo[CW-1] && (|quo[CW-2:0])) begin
					rsat_c[i] = 1'b1;
					res_c[i]  = Q_LO;
				end else begin
					res_c[i]  = CW'(-quo);
				end
			end else if (quo[CW-1]) begin
				rsat_c[i] = 1'b1;
				res_c[i]  = Q_HI;
			end else begin
				res_c[i] = quo;
			end
		end
	end

	logic          out_valid_q;
	logic [CW-1:0] qx_q, qy_q, qz_q;
	logic          sat_q;
	logic          zw_q;

	always_ff @(posedge clk) begin
		if (en) begin
			qx_q  <= res_c[0];
			qy_q  <= res_c[1];
			qz_q  <= res_c[2];
			sat_q <= fin.proj ? (|rsat_c) : fin.sat;
			zw_q  <= fin.proj && fin.zw;
		end
	end

	// valid bits of the front stages and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			dv_valid_sk[0] <= 1'b0;
			out_valid_q    <= 1'b0;
		end else if (en) begin
			valid_s1       <= in_valid;
			valid_s2       <= valid_s1;
			valid_s3       <= valid_s2;
			valid_s4       <= valid_s3;
			dv_valid_sk[0] <= valid_s4;
			out_valid_q    <= dv_valid_sk[CW];
		end
	end

	assign out_valid = out_valid_q;
	assign qx        = OUT_SEXT(qx_q);
	assign qy        = OUT_SEXT(qy_q);
	assign qz        = OUT_SEXT(qz_q);
	assign saturated = sat_q;
	assign zero_w    = zw_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`APT_ASSERT_NOW(a_stall_only_when_held, in_stall, out_valid && out_stall,
		"input stalled while output is free")
	`APT_ASSERT_NOW(a_zero_w_clean, out_valid && zero_w,
		!saturated && qx == 32'sd0 && qy == 32'sd0 && qz == 32'sd0,
		"zero w result not cleared")
	`APT_ASSERT_NEXT(a_held_result, out_valid && out_stall,
		out_valid && $stable(qx) && $stable(saturated),
		"held result changed under stall")

endmodule

### tb/sv/tb_affine_point_transform.sv
module tb_affine_point_transform;

	// wide signed type, enough for every exact intermediate of the transform
	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic signed [31:0] qz;
		logic               sat;
		logic               zw;
	} point_result_t;

	// expected transform results, plus a private copy of the matrix registers
	class transform_ledger;
		apt_pkg::cfg_word_t regs[apt_pkg::NUM_REGS];
		point_result_t      pending[$];
		int                 mismatches;

		function new();
			regs[0] = 64'd65536;
			regs[1] = 64'd0;
			regs[2] = 64'd65536 << 32;
			regs[3] = 64'd0;
			regs[4] = 64'd0;
			regs[5] = 64'd65536;
			regs[6] = 64'd0;
			regs[7] = 64'd65536 << 32;
			mismatches = 0;
		endfunction

		// indexes past the last register are dropped
		function void write_reg(logic [apt_pkg::CFG_IDX_W-1:0] idx, apt_pkg::cfg_word_t data);
			if (idx < apt_pkg::NUM_REGS)
				regs[idx] = data;
		endfunction

		function wide_t elem(int r, int c);
			logic signed [31:0] e;
			e = regs[r * 2 + c / 2][32 * (c % 2) +: 32];
			return e;
		endfunction

		// product truncated toward minus infinity
		function wide_t fmul(wide_t a, wide_t b);
			wide_t prod;
			prod = a * b;
			return prod >>> 16;
		endfunction

		function wide_t clamp(wide_t v, inout logic sat);
			wide_t hi, lo;
			hi = 128'sd2147483647;
			lo = -hi - 1;
			if (v > hi) begin
				sat = 1'b1;
				return hi;
			end
			if (v < lo) begin
				sat = 1'b1;
				return lo;
			end
			return v;
		endfunction

		// exact num * 2^16 / w, truncated toward zero, then saturated
		function wide_t proj_div(wide_t num, wide_t w, inout logic sat);
			wide_t n, d, q;
			n = (num < 0) ? -num : num;
			d = (w < 0) ? -w : w;
			q = (n <<< 16) / d;
			if ((num < 0) != (w < 0))
				q = -q;
			return clamp(q, sat);
		endfunction

		function void note_point(logic [2:0] kind, logic signed [31:0] px,
				logic signed [31:0] py, logic signed [31:0] pz);
			wide_t p[3], v[3], acc[3], w;
			point_result_t res;
			logic sat;
			sat = 1'b0;
			res.zw = 1'b0;
			p[0] = px;
			p[1] = py;
			p[2] = pz;
			if (kind == apt_pkg::KIND_ROT) begin
				for (int i = 0; i < 3; i++)
					acc[i] = fmul(elem(i, 0), p[0]) + fmul(elem(i, 1), p[1])
						+ fmul(elem(i, 2), p[2]);
			end else if (kind == apt_pkg::KIND_ROT_T || kind == apt_pkg::KIND_INV_RIGID) begin
				// inverse rigid keeps p - t exact
				for (int i = 0; i < 3; i++)
					v[i] = (kind == apt_pkg::KIND_INV_RIGID) ? p[i] - elem(i, 3) : p[i];
				for (int i = 0; i < 3; i++)
					acc[i] = fmul(elem(0, i), v[0]) + fmul(elem(1, i), v[1])
						+ fmul(elem(2, i), v[2]);
			end else begin
				// affine, projective, and unused codes
				for (int i = 0; i < 3; i++)
					acc[i] = fmul(elem(i, 0), p[0]) + fmul(elem(i, 1), p[1])
						+ fmul(elem(i, 2), p[2]) + elem(i, 3);
			end
			if (kind == apt_pkg::KIND_PROJ) begin
				w = fmul(elem(3, 0), p[0]) + fmul(elem(3, 1), p[1])
					+ fmul(elem(3, 2), p[2]) + elem(3, 3);
				if (w == 0) begin
					res.zw = 1'b1;
					for (int i = 0; i < 3; i++)
						acc[i] = 0;
				end else begin
					for (int i = 0; i < 3; i++)
						acc[i] = proj_div(acc[i], w, sat);
				end
			end else begin
				for (int i = 0; i < 3; i++)
					acc[i] = clamp(acc[i], sat);
			end
			res.qx = acc[0][31:0];
			res.qy = acc[1][31:0];
			res.qz = acc[2][31:0];
			res.sat = sat;
			pending.push_back(res);
		endfunction

		function void check_result(point_result_t got);
			point_result_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item qx=%h qy=%h qz=%h", got.qx, got.qy,
						got.qz);
				return;
			end
			exp = pending.pop_front();
			if (got.qx !== exp.qx || got.qy !== exp.qy || got.qz !== exp.qz
					|| got.sat !== exp.sat || got.zw !== exp.zw) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch exp q=(%h %h %h) sat=%b zw=%b got q=(%h %h %h) sat=%b zw=%b",
						exp.qx, exp.qy, exp.qz, exp.sat, exp.zw,
						got.qx, got.qy, got.qz, got.sat, got.zw);
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 60;   // above the pipe latency

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b1;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [2:0]                    kind = apt_pkg::KIND_AFFINE;
	logic signed [31:0]            px = '0;
	logic signed [31:0]            py = '0;
	logic signed [31:0]            pz = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [31:0]            qx;
	logic signed [31:0]            qy;
	logic signed [31:0]            qz;
	logic                          saturated;
	logic                          zero_w;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [apt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	apt_pkg::cfg_word_t            cfg_data = '0;

	transform_ledger ledger = new();
	bit  steady;      // when set, neither side idles
	int  quiet_cycles = 0;

	affine_point_transform u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.px        (px),
		.py        (py),
		.pz        (pz),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.qx        (qx),
		.qy        (qy),
		.qz        (qz),
		.saturated (saturated),
		.zero_w    (zero_w),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// watchdog: cycles in which no handshake completes on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stall before each item, then check it
	initial begin
		int gap;
		point_result_t got;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got.qx = qx;
			got.qy = qy;
			got.qz = qz;
			got.sat = saturated;
			got.zw = zero_w;
			ledger.check_result(got);
		end
	end

	// one input item, preceded by a random idle gap; valid stays high across back-to-back items
	task automatic send_point(logic [2:0] k, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		px <= x;
		py <= y;
		pz <= z;
		do @(posedge clk); while (in_stall);
		ledger.note_point(k, x, y, z);
	endtask

	// wait for every expected result, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (ledger.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_matrix(apt_pkg::cfg_word_t m[apt_pkg::NUM_REGS]);
		for (int i = 0; i < apt_pkg::NUM_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= apt_pkg::CFG_IDX_W'(i);
			cfg_data <= m[i];
			do @(posedge clk); while (!cfg_ready);
			ledger.write_reg(apt_pkg::CFG_IDX_W'(i), m[i]);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_elem(int style);
		case (style)
			0: return $urandom();
			1: return $urandom_range(0, 262143) - 131072;     // about +-2.0
			2: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(0, 131071) - 65536;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_coord(int style);
		case (style)
			0: return $urandom();
			1: return $urandom_range(0, 2097151) - 1048576;   // about +-16.0
			default:
				case ($urandom_range(0, 4))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
		endcase
	endfunction

	initial begin
		apt_pkg::cfg_word_t m[apt_pkg::NUM_REGS];
		int style;
		int cstyle;
		logic signed [31:0] extremes[4];
		extremes = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh00010000};
		steady = 1'b0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset: every transform, extreme coordinates
		send_point(apt_pkg::KIND_AFFINE, extremes[0], extremes[1], extremes[2]);
		send_point(apt_pkg::KIND_ROT, extremes[1], extremes[0], extremes[3]);
		send_point(apt_pkg::KIND_ROT_T, extremes[3], extremes[2], extremes[0]);
		send_point(apt_pkg::KIND_INV_RIGID, extremes[0], extremes[0], extremes[1]);
		send_point(apt_pkg::KIND_PROJ, extremes[1], extremes[3], extremes[0]);
		send_point(3'd5, -1, 1, 32'sh12345678);
		send_point(3'd6, 7, -7, 0);
		send_point(3'd7, extremes[1], extremes[1], extremes[1]);
		drain();

		// extreme matrix: saturation everywhere, inverse rigid with large translation
		for (int i = 0; i < apt_pkg::NUM_REGS; i++)
			m[i] = {pick_elem(2), pick_elem(2)};
		write_matrix(m);
		for (int k = 0; k < 5; k++)
			send_point(3'(k), extremes[k % 4], extremes[(k + 1) % 4], extremes[(k + 2) % 4]);
		send_point(apt_pkg::KIND_INV_RIGID, extremes[1], extremes[1], extremes[1]);
		drain();

		// projective row all zero: w is zero for every point
		for (int i = 0; i < apt_pkg::NUM_REGS; i++)
			m[i] = (i >= 6) ? 64'd0 : {pick_elem(1), pick_elem(1)};
		write_matrix(m);
		send_point(apt_pkg::KIND_PROJ, 32'sh00010000, -5, 32'sh7fffffff);
		send_point(apt_pkg::KIND_PROJ, 0, 0, 0);
		send_point(apt_pkg::KIND_AFFINE, 3, 4, 5);
		drain();

		// an index past the last register is dropped
		cfg_valid <= 1'b1;
		cfg_index <= apt_pkg::CFG_IDX_W'(apt_pkg::NUM_REGS);
		cfg_data <= '1;
		do @(posedge clk); while (!cfg_ready);
		ledger.write_reg(apt_pkg::CFG_IDX_W'(apt_pkg::NUM_REGS), '1);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_point(apt_pkg::KIND_ROT, 32'sh00020000, 32'sh00030000, -32'sh00010000);
		drain();

		// random phases, one matrix per phase
		for (int ph = 0; ph < 12; ph++) begin
			cstyle = (ph % 5 == 0) ? 0 : ((ph % 5 == 1) ? 2 : ((ph % 5 == 4) ? 3 : 1));
			for (int i = 0; i < apt_pkg::NUM_REGS; i++)
				m[i] = {pick_elem(cstyle), pick_elem(cstyle)};
			// sometimes a small projective row so that w lands on zero now and then
			if (ph % 4 == 3) begin
				m[6] = {32'($urandom_range(0, 2) - 1), 32'($urandom_range(0, 2) - 1)};
				m[7] = {32'($urandom_range(0, 2) - 1) <<< 16, 32'($urandom_range(0, 2) - 1)};
			end
			write_matrix(m);
			steady = (ph % 3 == 2);
			for (int n = 0; n < 160; n++) begin
				style = $urandom_range(0, 9);
				style = (style < 3) ? 0 : ((style < 8) ? 1 : 2);
				send_point(($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
						: 3'($urandom_range(0, 4)),
					pick_coord(style), pick_coord(style), pick_coord(style));
			end
			steady = 1'b0;
			drain();
		end

		if (ledger.pending.size() == 0 && ledger.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
